// ===== rtl/core/blfc_pkg.sv =====
// shared types and constants of the band and local oscillator calculator
`default_nettype none

package blfc_pkg;

  localparam int unsigned FreqW      = 32;
  localparam int unsigned DevW       = 8;
  localparam int unsigned BandW      = 2;
  localparam int unsigned CodeW      = 2;
  localparam int unsigned ThrW       = 16;
  localparam int unsigned ProdW      = 2 * FreqW;
  localparam int unsigned LoShift    = 21;

  // number of bands in use, 2 to 4
  localparam int unsigned BandCount  = 4;
  localparam int unsigned NumThr     = BandCount - 1;
  // register slots fixed by the register map
  localparam int unsigned BandRegs   = 4;
  localparam int unsigned ThrRegs    = 3;

  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 64;
  localparam logic [FreqW-1:0] GainReset = 32'h0020_0000;

  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegCrossover   = 8'd0,
    RegBand0       = 8'd1,
    RegBand1       = 8'd2,
    RegBand2       = 8'd3,
    RegBand3       = 8'd4,
    RegFilterCodes = 8'd5,
    RegFilterEn    = 8'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ThrRegs-1:0][ThrW-1:0]    thr;
    logic [BandRegs-1:0][FreqW-1:0]  offset;
    logic [BandRegs-1:0][FreqW-1:0]  gain;
    logic [BandRegs-1:0][CodeW-1:0]  fcode;
    logic                            fen;
  } cfg_t;

  // one classified request waiting for the multiplier
  typedef struct packed {
    logic [FreqW-1:0] diff;
    logic [FreqW-1:0] gain;
    logic [BandW-1:0] band;
    logic [CodeW-1:0] fcode;
    logic             fdrive;
    logic [DevW-1:0]  dev;
  } entry_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/blfc_if.sv =====
// channel interfaces: tuning requests, results and register writes
`default_nettype none

interface blfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [blfc_pkg::FreqW-1:0]    tune_freq;
  logic [blfc_pkg::DevW-1:0]     device_index;

  modport source (output valid, output tune_freq, output device_index, input ready);
  modport sink   (input valid, input tune_freq, input device_index, output ready);
endinterface

interface blfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [blfc_pkg::FreqW-1:0]    lo_freq;
  logic [blfc_pkg::BandW-1:0]    band_sel;
  logic [blfc_pkg::CodeW-1:0]    filter_code;
  logic                          filter_drive;
  logic [blfc_pkg::DevW-1:0]     device_index_out;

  modport source (output valid, output lo_freq, output band_sel, output filter_code,
                  output filter_drive, output device_index_out, input ready);
  modport sink   (input valid, input lo_freq, input band_sel, input filter_code,
                  input filter_drive, input device_index_out, output ready);
endinterface

interface blfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [blfc_pkg::CfgIdxW-1:0]   index;
  logic [blfc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/blfc_cfg.sv =====
// configuration register file
`default_nettype none

module blfc_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  blfc_cfg_if.sink         cfg_i,
  output blfc_pkg::cfg_t   cfg_o
);

  blfc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        blfc_pkg::RegCrossover: begin
          cfg_d.thr = cfg_i.data[blfc_pkg::ThrRegs*blfc_pkg::ThrW-1:0];
        end
        blfc_pkg::RegBand0: begin
          cfg_d.offset[0] = cfg_i.data[blfc_pkg::FreqW-1:0];
          cfg_d.gain[0]   = cfg_i.data[2*blfc_pkg::FreqW-1:blfc_pkg::FreqW];
        end
        blfc_pkg::RegBand1: begin
          cfg_d.offset[1] = cfg_i.data[blfc_pkg::FreqW-1:0];
          cfg_d.gain[1]   = cfg_i.data[2*blfc_pkg::FreqW-1:blfc_pkg::FreqW];
        end
        blfc_pkg::RegBand2: begin
          cfg_d.offset[2] = cfg_i.data[blfc_pkg::FreqW-1:0];
          cfg_d.gain[2]   = cfg_i.data[2*blfc_pkg::FreqW-1:blfc_pkg::FreqW];
        end
        blfc_pkg::RegBand3: begin
          cfg_d.offset[3] = cfg_i.data[blfc_pkg::FreqW-1:0];
          cfg_d.gain[3]   = cfg_i.data[2*blfc_pkg::FreqW-1:blfc_pkg::FreqW];
        end
        blfc_pkg::RegFilterCodes: begin
          cfg_d.fcode = cfg_i.data[blfc_pkg::BandRegs*blfc_pkg::CodeW-1:0];
        end
        blfc_pkg::RegFilterEn: begin
          cfg_d.fen = cfg_i.data[0];
        end
        default: begin
          // unmapped index, write dropped
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr    <= '0;
      cfg_q.offset <= '0;
      cfg_q.gain   <= {blfc_pkg::BandRegs{blfc_pkg::GainReset}};
      cfg_q.fcode  <= '0;
      cfg_q.fen    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/blfc_front.sv =====
// front part: band selection and offset subtraction
`default_nettype none

module blfc_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  blfc_in_if.sink                    in_i,
  input  wire blfc_pkg::cfg_t        cfg_i,
  input  wire blfc_pkg::fifo_status_t status_i,
  output logic                       push_o,
  output blfc_pkg::entry_t           entry_o
);

  logic                          valid_q;
  logic [blfc_pkg::FreqW-1:0]    freq_q;
  logic [blfc_pkg::BandW-1:0]    band_q, band_d;
  logic [blfc_pkg::DevW-1:0]     dev_q;
  logic [blfc_pkg::ThrW-1:0]     freq_hi;
  logic [blfc_pkg::FreqW-1:0]    offset;

  assign freq_hi = in_i.tune_freq[blfc_pkg::FreqW-1 -: blfc_pkg::ThrW];

  // first threshold above the upper half wins, else the last band
  always_comb begin
    band_d = blfc_pkg::BandW'(blfc_pkg::BandCount - 1);
    for (int n = blfc_pkg::NumThr - 1; n >= 0; n--) begin
      if (freq_hi < cfg_i.thr[n]) begin
        band_d = blfc_pkg::BandW'(n);
      end
    end
  end

  assign push_o     = valid_q && !status_i.full;
  assign in_i.ready = !valid_q || push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      freq_q <= in_i.tune_freq;
      band_q <= band_d;
      dev_q  <= in_i.device_index;
    end
  end

  assign offset = cfg_i.offset[band_q];

  always_comb begin
    entry_o.diff   = (offset <= freq_q) ? freq_q - offset : freq_q;
    entry_o.gain   = cfg_i.gain[band_q];
    entry_o.band   = band_q;
    entry_o.fcode  = cfg_i.fcode[band_q];
    entry_o.fdrive = cfg_i.fen;
    entry_o.dev    = dev_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/blfc_fifo.sv =====
// short queue between the front and back parts
`default_nettype none

module blfc_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire blfc_pkg::entry_t       entry_i,
  input  wire logic                   pop_i,
  output blfc_pkg::entry_t            entry_o,
  output blfc_pkg::fifo_status_t      status_o
);

  blfc_pkg::entry_t               mem_q [blfc_pkg::FifoDepth];
  logic [blfc_pkg::PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [blfc_pkg::PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [blfc_pkg::CntW-1:0]      count_q, count_d;
  logic                           push, pop;

  assign status_o.full  = (count_q == blfc_pkg::CntW'(blfc_pkg::FifoDepth));
  assign status_o.empty = (count_q == '0);
  assign push = push_i && !status_o.full;
  assign pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == blfc_pkg::PtrW'(blfc_pkg::FifoDepth - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == blfc_pkg::PtrW'(blfc_pkg::FifoDepth - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o = mem_q[rd_ptr_q];

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= blfc_pkg::CntW'(blfc_pkg::FifoDepth))
    else $error("queue fill count beyond depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == blfc_pkg::CntW'($past(count_q) + 1'b1))
    else $error("queue fill count did not follow a lone push");

  a_count_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == blfc_pkg::CntW'($past(count_q) - 1'b1))
    else $error("queue fill count did not follow a lone pop");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/blfc_back.sv =====
// back part: gain multiply and result register
`default_nettype none

module blfc_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire blfc_pkg::entry_t       entry_i,
  input  wire blfc_pkg::fifo_status_t status_i,
  output logic                        pop_o,
  blfc_out_if.source                  out_o
);

  logic                          valid_q;
  logic [blfc_pkg::FreqW-1:0]    lo_q;
  logic [blfc_pkg::BandW-1:0]    band_q;
  logic [blfc_pkg::CodeW-1:0]    fcode_q;
  logic                          fdrive_q;
  logic [blfc_pkg::DevW-1:0]     dev_q;
  logic [blfc_pkg::ProdW-1:0]    prod;

  assign pop_o = !status_i.empty && (!valid_q || out_o.ready);

  // full product, the window above the fraction is kept and wraps
  assign prod = blfc_pkg::ProdW'(entry_i.diff) * blfc_pkg::ProdW'(entry_i.gain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_o.ready) begin
      valid_q <= !status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lo_q     <= prod[blfc_pkg::LoShift +: blfc_pkg::FreqW];
      band_q   <= entry_i.band;
      fcode_q  <= entry_i.fcode;
      fdrive_q <= entry_i.fdrive;
      dev_q    <= entry_i.dev;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.lo_freq          = lo_q;
  assign out_o.band_sel         = band_q;
  assign out_o.filter_code      = fcode_q;
  assign out_o.filter_drive     = fdrive_q;
  assign out_o.device_index_out = dev_q;

endmodule

`default_nettype wire

// ===== rtl/core/band_lo_frequency_calc.sv =====
// top level of the band select and local oscillator calculator
//
// in_i takes one tuning request per handshake: tune_freq (unsigned 11.21 MHz)
// and device_index. out_o returns one result per request, in order: the
// local oscillator word ((freq - offset) * gain) >> 21 on 32 wrapping bits
// (freq itself if the offset exceeds it), the band, its filter code, the
// filter drive flag and the device index. cfg_i writes the register map
// (index 0 crossover points, 1 to 4 band offset and gain, 5 filter codes,
// 6 filter enable); unmapped indexes are dropped. write only while no
// request is in flight. the band is picked as the request enters the front
// register, the offset comes off on the way into the queue, and the
// combinational 32x32 multiply on the queue head fills the output register.
// throughput: one request per cycle while the receiver takes results.
// a four-entry queue sits between the front and the multiplier; when the
// receiver stalls, the output register holds, the queue fills and in_i.ready
// falls only once the queue and the front register are full.
// reset clears all valid state and loads the registers with zero thresholds,
// zero offsets, unity gain and filter drive off.
`default_nettype none

module band_lo_frequency_calc (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  blfc_in_if.sink       in_i,
  blfc_out_if.source    out_o,
  blfc_cfg_if.sink      cfg_i
);

  blfc_pkg::cfg_t          cfg;
  blfc_pkg::entry_t        push_entry;
  blfc_pkg::entry_t        head_entry;
  blfc_pkg::fifo_status_t  status;
  logic                    push;
  logic                    pop;

  blfc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  blfc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .status_i (status),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  blfc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (status)
  );

  blfc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (head_entry),
    .status_i (status),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
